// ===== hw/rtl/sac_pkg.sv =====
// types, constants and codes shared by the slot chooser files
package sac_pkg;

  localparam int unsigned SETS   = 128;
  localparam int unsigned WAYS   = 8;
  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned SLOTS  = SETS * WAYS;

  localparam int unsigned PAGE_W = 20;
  localparam int unsigned RWAY_W = 3;
  localparam int unsigned SLOT_W = 10;
  localparam int unsigned ST_W   = 2;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic [ST_W-1:0] {
    ST_UNMAP = 2'd0,
    ST_INV   = 2'd1,
    ST_RO    = 2'd2,
    ST_RW    = 2'd3
  } slot_st_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic {
    REPL_RANDOM   = 1'b0,
    REPL_CIRCULAR = 1'b1
  } repl_e;

  typedef enum logic {
    REG_REPL_MODE   = 1'b0,
    REG_REGION_BASE = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_SCAN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              cmd;
    logic [PAGE_W-1:0] page_number;
    logic [RWAY_W-1:0] random_way;
    logic [SLOT_W-1:0] target_slot;
    logic [ST_W-1:0]   new_state;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] chosen_slot;
    logic              fail;
  } out_item_t;

  // one memory row holds a whole set: its way counter and the state of every slot
  typedef struct packed {
    logic [WAY_W-1:0]        next_way;
    slot_st_e [WAYS-1:0]     st;
  } row_t;

  typedef struct packed {
    logic              repl_mode;
    logic [PAGE_W-1:0] region_base_page;
  } cfg_t;

endpackage

// ===== hw/rtl/sac_if.sv =====
// valid/ready channel interfaces for command items and result items
interface sac_in_if;
  logic                valid;
  logic                ready;
  sac_pkg::in_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface sac_out_if;
  logic                valid;
  logic                ready;
  sac_pkg::out_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/sac_cfg.sv =====
// apb register file: replacement mode and shared region base page
module sac_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sac_pkg::APB_AW-1:0]   paddr,
  input  logic [sac_pkg::APB_DW-1:0]   pwdata,
  output logic [sac_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output sac_pkg::cfg_t                cfg_o
);

  logic                         repl_mode_q;
  logic [sac_pkg::PAGE_W-1:0]   region_base_q;
  sac_pkg::cfg_reg_e            reg_sel;
  logic                         wr_en;

  // registers sit on a 4 byte stride, low address bits ignored
  assign reg_sel = sac_pkg::cfg_reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_mode_q   <= sac_pkg::REPL_CIRCULAR;
      region_base_q <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        sac_pkg::REG_REPL_MODE:   repl_mode_q   <= pwdata[0];
        sac_pkg::REG_REGION_BASE: region_base_q <= pwdata[sac_pkg::PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      sac_pkg::REG_REPL_MODE:   prdata = sac_pkg::APB_DW'(repl_mode_q);
      sac_pkg::REG_REGION_BASE: prdata = sac_pkg::APB_DW'(region_base_q);
      default: ;
    endcase
  end

  assign cfg_o.repl_mode        = repl_mode_q;
  assign cfg_o.region_base_page = region_base_q;

endmodule

// ===== hw/rtl/set_assoc_slot_chooser.sv =====
// slot chooser top level: set memory, way scan sequencer and result register
//
//   channel | dir | handshake        | payload
//   in_i    | in  | valid / ready    | cmd, page_number, random_way, target_slot, new_state
//   out_o   | out | valid / ready    | chosen_slot, fail
//   apb     | in  | psel/penable     | repl_mode, region_base_page
//
// one item at a time: accept with the set row read, a load state, a scan state that visits
// one way at a time (1 to WAYS ways), then a write-back state; a state write goes from the
// load state straight to write-back.
// reset marks every set row not yet written, which reads as all slots unmapped and
// counter zero, so no clearing pass is needed. a stalled result holds the write-back
// state until the result register frees up.
module set_assoc_slot_chooser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sac_in_if.sink                       in_i,
  sac_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sac_pkg::APB_AW-1:0]   paddr,
  input  logic [sac_pkg::APB_DW-1:0]   pwdata,
  output logic [sac_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned SetW  = sac_pkg::SET_W;
  localparam int unsigned WayW  = sac_pkg::WAY_W;
  localparam int unsigned SlotW = sac_pkg::SLOT_W;

  sac_pkg::cfg_t      cfg;
  sac_pkg::state_e    state_q, state_d;

  // set memory, one row per set, with a written flag per row
  sac_pkg::row_t      mem_q [sac_pkg::SETS];
  logic [sac_pkg::SETS-1:0] row_vld_q;

  sac_pkg::in_item_t  in_q;
  logic [SetW-1:0]    set_q;
  logic               rowv_q;
  sac_pkg::row_t      rd_q;
  sac_pkg::row_t      row_q;
  logic [WayW-1:0]    way_q;
  logic [WayW-1:0]    cnt_q;
  logic               have_inv_q;
  logic [WayW-1:0]    inv_q;
  logic [WayW-1:0]    victim_q;
  logic               out_vld_q;
  sac_pkg::out_item_t out_q;

  logic               in_acc;
  logic [SetW-1:0]    page_set;
  logic [SetW-1:0]    tgt_set;
  logic [SetW-1:0]    rd_set;
  logic [sac_pkg::PAGE_W-1:0] page_off;

  sac_pkg::row_t      row_cur;
  sac_pkg::row_t      row_load;
  logic [WayW-1:0]    start_way;
  logic [WayW-1:0]    tgt_way;
  logic               tgt_in_range;
  logic               is_write;

  sac_pkg::slot_st_e  cur_st;
  logic               scan_hit;
  logic               scan_last;
  logic               inv_now;
  logic [WayW-1:0]    way_inc;
  logic [WayW-1:0]    scan_victim;

  sac_pkg::slot_st_e  vic_st;
  logic               res_fail;
  sac_pkg::row_t      wr_row;
  sac_pkg::out_item_t res;
  logic               go;
  logic               wr_en;

  sac_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------- input side
  assign in_i.ready = (state_q == sac_pkg::S_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;

  // page offset wraps within 20 bits, set is its low bits
  assign page_off = in_i.item.page_number - cfg.region_base_page;
  assign page_set = page_off[SetW-1:0];
  assign tgt_set  = SetW'(in_i.item.target_slot >> WayW);
  assign rd_set   = (in_i.item.cmd == sac_pkg::CMD_WRITE) ? tgt_set : page_set;

  // ---------------------------------------------------------------- load cycle
  assign is_write     = (in_q.cmd == sac_pkg::CMD_WRITE);
  assign row_cur      = rowv_q ? rd_q : '0;
  assign tgt_way      = in_q.target_slot[WayW-1:0];
  assign tgt_in_range = ({1'b0, in_q.target_slot} < (SlotW + 1)'(sac_pkg::SLOTS));
  assign start_way    = (cfg.repl_mode == sac_pkg::REPL_CIRCULAR)
                        ? WayW'((32'(row_cur.next_way) + 32'd1) % sac_pkg::WAYS)
                        : WayW'(32'(in_q.random_way) % sac_pkg::WAYS);

  always_comb begin
    row_load = row_cur;
    if (is_write) begin
      if (tgt_in_range) begin
        row_load.st[tgt_way] = sac_pkg::slot_st_e'(in_q.new_state);
      end
    end else if (cfg.repl_mode == sac_pkg::REPL_CIRCULAR) begin
      row_load.next_way = start_way;
    end
  end

  // ---------------------------------------------------------------- scan cycle
  assign cur_st    = row_q.st[way_q];
  assign scan_hit  = (cur_st == sac_pkg::ST_UNMAP);
  assign scan_last = (cnt_q == WayW'(sac_pkg::WAYS - 1));
  assign inv_now   = !have_inv_q && (cur_st == sac_pkg::ST_INV);
  assign way_inc   = WayW'((32'(way_q) + 32'd1) % sac_pkg::WAYS);

  // after a full lap the way is back at the start way
  always_comb begin
    priority if (scan_hit) begin
      scan_victim = way_q;
    end else if (have_inv_q) begin
      scan_victim = inv_q;
    end else if (inv_now) begin
      scan_victim = way_q;
    end else begin
      scan_victim = way_inc;
    end
  end

  // ---------------------------------------------------------------- write-back
  assign vic_st   = row_q.st[victim_q];
  assign res_fail = !is_write && (vic_st == sac_pkg::ST_RW);
  assign go       = !out_vld_q || out_o.ready;
  assign wr_en    = (state_q == sac_pkg::S_FINISH) && go;

  always_comb begin
    wr_row = row_q;
    if (!is_write && !res_fail) begin
      wr_row.st[victim_q] = sac_pkg::ST_UNMAP;
    end
    res.fail        = res_fail;
    res.chosen_slot = (!is_write && !res_fail) ? SlotW'({set_q, victim_q}) : '0;
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sac_pkg::S_IDLE:   if (in_acc) state_d = sac_pkg::S_LOAD;
      sac_pkg::S_LOAD:   state_d = is_write ? sac_pkg::S_FINISH : sac_pkg::S_SCAN;
      sac_pkg::S_SCAN:   if (scan_hit || scan_last) state_d = sac_pkg::S_FINISH;
      sac_pkg::S_FINISH: if (go) state_d = sac_pkg::S_IDLE;
      default:           state_d = sac_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sac_pkg::S_IDLE;
      row_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        row_vld_q[set_q] <= 1'b1;
      end
      if (wr_en) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // set memory: one read port, one write port, read data registered
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem_q[rd_set];
    end
    if (wr_en) begin
      mem_q[set_q] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q   <= in_i.item;
      set_q  <= rd_set;
      rowv_q <= row_vld_q[rd_set];
    end
    unique case (state_q)
      sac_pkg::S_LOAD: begin
        row_q      <= row_load;
        way_q      <= start_way;
        cnt_q      <= '0;
        have_inv_q <= 1'b0;
      end
      sac_pkg::S_SCAN: begin
        if (inv_now) begin
          have_inv_q <= 1'b1;
          inv_q      <= way_q;
        end
        way_q    <= way_inc;
        cnt_q    <= cnt_q + WayW'(1);
        victim_q <= scan_victim;
      end
      default: ;
    endcase
    if (wr_en) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.item  = out_q;

endmodule

// ===== hw/rtl/sac_checker.sv =====
// port-level checks for the slot chooser, bound to the top level
module sac_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [sac_pkg::SLOT_W-1:0]  out_chosen_slot,
  input logic                        out_fail
);

  // one item in flight: no new item right after one is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while previous item still in flight");

  // a result needs at least the row read before it appears
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !$rose(out_valid))
    else $error("result raised in the cycle after accept");

  // a failed allocate reports no slot
  a_fail_no_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_fail) |-> (out_chosen_slot == '0))
    else $error("failed item carries a slot index");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_chosen_slot) && $stable(out_fail)))
    else $error("stalled result changed");

endmodule

bind set_assoc_slot_chooser sac_checker u_sac_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_i.valid),
  .in_ready        (in_i.ready),
  .out_valid       (out_o.valid),
  .out_ready       (out_o.ready),
  .out_chosen_slot (out_o.item.chosen_slot),
  .out_fail        (out_o.item.fail)
);

// ===== verif/set_assoc_slot_chooser_tb.sv =====
// testbench for the set-associative slot chooser: directed table, random phases, self-checking
`timescale 1ns / 1ps

module set_assoc_slot_chooser_tb;

  typedef struct {
    bit                         is_cfg;
    sac_pkg::repl_e             mode;
    logic [sac_pkg::PAGE_W-1:0] base;
    sac_pkg::in_item_t          it;
    bit                         typed;
    sac_pkg::out_item_t         want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sac_pkg::APB_AW-1:0] paddr;
  logic [sac_pkg::APB_DW-1:0] pwdata;
  logic [sac_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic res_ready = 1'b0;

  sac_in_if  in_if ();
  sac_out_if out_if ();

  assign out_if.ready = res_ready;

  set_assoc_slot_chooser dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted cache state and register copy
  sac_pkg::slot_st_e          slot_st_m [sac_pkg::SLOTS];
  logic [sac_pkg::WAY_W-1:0]  way_ctr_m [sac_pkg::SETS];
  sac_pkg::repl_e             cfg_mode_m;
  logic [sac_pkg::PAGE_W-1:0] cfg_base_m;

  sac_pkg::out_item_t expected_picks [$];
  sac_pkg::out_item_t head_pick;
  stim_row_t dir_rows [$];

  bit calm = 1'b0;
  int unsigned errs    = 0;
  int unsigned n_alloc = 0;
  int unsigned n_write = 0;
  int unsigned n_fail  = 0;
  int unsigned n_cfg   = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic sac_pkg::out_item_t choose_slot(sac_pkg::in_item_t it);
    sac_pkg::out_item_t         res;
    logic [sac_pkg::PAGE_W-1:0] rel;
    int unsigned                set_idx;
    int unsigned                way;
    int unsigned                inv_way;
    int unsigned                n;
    bit                         have_inv;
    sac_pkg::slot_st_e          st;
    res = '0;
    if (it.cmd == sac_pkg::CMD_WRITE) begin
      if (it.target_slot < sac_pkg::SLOTS) begin
        slot_st_m[it.target_slot] = sac_pkg::slot_st_e'(it.new_state);
      end
      return res;
    end
    rel = it.page_number - cfg_base_m;
    set_idx = rel % sac_pkg::SETS;
    if (cfg_mode_m == sac_pkg::REPL_RANDOM) begin
      way = it.random_way % sac_pkg::WAYS;
    end else begin
      way = (way_ctr_m[set_idx] + 1) % sac_pkg::WAYS;
      way_ctr_m[set_idx] = sac_pkg::WAY_W'(way);
    end
    have_inv = 1'b0;
    inv_way = 0;
    n = 0;
    while (n < sac_pkg::WAYS &&
           slot_st_m[set_idx * sac_pkg::WAYS + way] != sac_pkg::ST_UNMAP) begin
      if (!have_inv && slot_st_m[set_idx * sac_pkg::WAYS + way] == sac_pkg::ST_INV) begin
        have_inv = 1'b1;
        inv_way = way;
      end
      way = (way + 1) % sac_pkg::WAYS;
      n++;
    end
    // no free slot met: the first invalid one beats the start way
    if (slot_st_m[set_idx * sac_pkg::WAYS + way] != sac_pkg::ST_UNMAP && have_inv) begin
      way = inv_way;
    end
    st = slot_st_m[set_idx * sac_pkg::WAYS + way];
    if (st == sac_pkg::ST_RW) begin
      res.fail = 1'b1;
      return res;
    end
    if (st == sac_pkg::ST_INV || st == sac_pkg::ST_RO) begin
      slot_st_m[set_idx * sac_pkg::WAYS + way] = sac_pkg::ST_UNMAP;
    end
    res.chosen_slot = sac_pkg::SLOT_W'(set_idx * sac_pkg::WAYS + way);
    return res;
  endfunction

  function automatic stim_row_t alloc_row(logic [sac_pkg::PAGE_W-1:0] page,
                                          logic [sac_pkg::RWAY_W-1:0] rway,
                                          int want_slot = -1, bit want_fail = 1'b0);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.mode = sac_pkg::REPL_CIRCULAR;
    r.base = '0;
    r.it = '0;
    r.it.cmd = sac_pkg::CMD_ALLOC;
    r.it.page_number = page;
    r.it.random_way = rway;
    r.typed = (want_slot >= 0);
    r.want.chosen_slot = sac_pkg::SLOT_W'(want_slot);
    r.want.fail = want_fail;
    return r;
  endfunction

  function automatic stim_row_t write_row(logic [sac_pkg::SLOT_W-1:0] slot,
                                          sac_pkg::slot_st_e st);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.mode = sac_pkg::REPL_CIRCULAR;
    r.base = '0;
    r.it = '0;
    r.it.cmd = sac_pkg::CMD_WRITE;
    r.it.target_slot = slot;
    r.it.new_state = st;
    r.typed = 1'b1;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(sac_pkg::repl_e mode,
                                        logic [sac_pkg::PAGE_W-1:0] base);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.mode = mode;
    r.base = base;
    r.it = '0;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errs++;
  endtask

  task automatic send_item(sac_pkg::in_item_t it, bit typed, sac_pkg::out_item_t want);
    sac_pkg::out_item_t pred;
    if (!calm && $urandom_range(99) < 6) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pred = choose_slot(it);
    expected_picks.push_back(typed ? want : pred);
    if (it.cmd == sac_pkg::CMD_ALLOC) n_alloc++;
    else n_write++;
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk_i);
    repeat (sac_pkg::WAYS + 4) @(posedge clk_i);
  endtask

  task automatic apb_write(sac_pkg::cfg_reg_e r, logic [sac_pkg::APB_DW-1:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= sac_pkg::APB_AW'(int'(r) * 4);
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    unique case (r)
      sac_pkg::REG_REPL_MODE:   cfg_mode_m = sac_pkg::repl_e'(v[0]);
      sac_pkg::REG_REGION_BASE: cfg_base_m = v[sac_pkg::PAGE_W-1:0];
    endcase
    n_cfg++;
  endtask

  task automatic set_config(sac_pkg::repl_e mode, logic [sac_pkg::PAGE_W-1:0] base);
    drain_results();
    apb_write(sac_pkg::REG_REPL_MODE, sac_pkg::APB_DW'(mode));
    apb_write(sac_pkg::REG_REGION_BASE, sac_pkg::APB_DW'(base));
  endtask

  // result side: random stalls, compare against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && res_ready) begin
      if (expected_picks.size() == 0) begin
        flag_mismatch("result item with nothing pending");
      end else begin
        head_pick = expected_picks.pop_front();
        if (out_if.item.chosen_slot !== head_pick.chosen_slot)
          flag_mismatch($sformatf("chosen_slot %0d, wanted %0d",
                                  out_if.item.chosen_slot, head_pick.chosen_slot));
        if (out_if.item.fail !== head_pick.fail)
          flag_mismatch($sformatf("fail %0b, wanted %0b", out_if.item.fail, head_pick.fail));
        if (head_pick.fail) n_fail++;
      end
    end
    res_ready <= calm || ($urandom_range(99) >= 6);
  end

  initial begin
    sac_pkg::in_item_t          it;
    sac_pkg::repl_e             mode;
    logic [sac_pkg::PAGE_W-1:0] base;
    int unsigned                hot [3];
    int unsigned                set_idx;

    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int i = 0; i < sac_pkg::SLOTS; i++) slot_st_m[i] = sac_pkg::ST_UNMAP;
    for (int i = 0; i < sac_pkg::SETS; i++) way_ctr_m[i] = '0;
    cfg_mode_m = sac_pkg::REPL_CIRCULAR;
    cfg_base_m = '0;

    // fills set 2 with read-write slots, then works through the victim rules on it
    dir_rows = '{
      alloc_row(20'h00000, 3'd0, 1),
      alloc_row(20'hFFFFF, 3'd0, 1017),
      write_row(10'd1023, sac_pkg::ST_RW),
      write_row(10'd16, sac_pkg::ST_RW), write_row(10'd17, sac_pkg::ST_RW),
      write_row(10'd18, sac_pkg::ST_RW), write_row(10'd19, sac_pkg::ST_RW),
      write_row(10'd20, sac_pkg::ST_RW), write_row(10'd21, sac_pkg::ST_RW),
      write_row(10'd22, sac_pkg::ST_RW), write_row(10'd23, sac_pkg::ST_RW),
      alloc_row(20'h00002, 3'd0, 0, 1'b1),
      write_row(10'd19, sac_pkg::ST_INV),
      write_row(10'd21, sac_pkg::ST_RO),
      alloc_row(20'h00002, 3'd0),
      alloc_row(20'h00002, 3'd0),
      write_row(10'd19, sac_pkg::ST_RW),
      alloc_row(20'h00002, 3'd0),
      alloc_row(20'h00002, 3'd0),
      write_row(10'd17, sac_pkg::ST_UNMAP),
      cfg_row(sac_pkg::REPL_RANDOM, 20'hFFFFF),
      alloc_row(20'h00000, 3'd7, 15),
      alloc_row(20'hFFFFE, 3'd0, 1016),
      alloc_row(20'h00001, 3'd5)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(sac_pkg::REPL_CIRCULAR, '0);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_config(dir_rows[i].mode, dir_rows[i].base);
      else send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 4) begin
        mode = sac_pkg::repl_e'(ph % 2);
        base = (ph == 1 || ph == 2) ? '1 : '0;
      end else begin
        mode = sac_pkg::repl_e'($urandom_range(1));
        base = sac_pkg::PAGE_W'($urandom);
      end
      calm = 1'b0;
      set_config(mode, base);
      calm = (ph == 4 || ph == 5);
      foreach (hot[k]) hot[k] = $urandom_range(sac_pkg::SETS - 1);
      for (int n = 0; n < 50; n++) begin
        it.cmd = ($urandom_range(99) < 55) ? sac_pkg::CMD_ALLOC : sac_pkg::CMD_WRITE;
        it.page_number = sac_pkg::PAGE_W'($urandom);
        it.random_way = sac_pkg::RWAY_W'($urandom);
        it.target_slot = sac_pkg::SLOT_W'($urandom);
        it.new_state = sac_pkg::ST_W'($urandom);
        // mostly aim at a few sets so they fill up and the victim rules get exercised
        if ($urandom_range(9) < 8) begin
          set_idx = hot[$urandom_range(2)];
          it.page_number = sac_pkg::PAGE_W'(cfg_base_m + set_idx + ($urandom << 7));
          it.target_slot = sac_pkg::SLOT_W'(set_idx * sac_pkg::WAYS +
                                            $urandom_range(sac_pkg::WAYS - 1));
          if ($urandom_range(99) < 45) it.new_state = sac_pkg::ST_RW;
        end
        send_item(it, 1'b0, '0);
      end
    end
    calm = 1'b0;
    drain_results();

    $display("ran %0d allocates (%0d expected to fail) and %0d state writes", n_alloc, n_fail,
             n_write);
    $display("over %0d register writes, both replacement modes, region base at both ends",
             n_cfg);
    if (errs == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sac_pkg.sv
hw/rtl/sac_if.sv
hw/rtl/sac_cfg.sv
hw/rtl/set_assoc_slot_chooser.sv
hw/rtl/sac_checker.sv
verif/set_assoc_slot_chooser_tb.sv
